### design/zofbc_pkg.sv
// ----------------------------------------------------------------------------
// zofbc_pkg
// Shared types, codes and helpers of the zoned order free block cache.
// ----------------------------------------------------------------------------
package zofbc_pkg;

   localparam int ZONES   = 3;
   localparam int PAGE_W  = 16;
   localparam int ORDER_W = 5;
   localparam int ADDR_W  = 52;
   localparam int START_W = 33;
   localparam int END_W   = 53;
   localparam int TOTAL_W = 20;
   localparam int LCNT_W  = 7;

   localparam logic [END_W-1:0] DMA32_LIMIT = 53'h0_0000_4000_0000;
   localparam logic [END_W-1:0] USER_LIMIT  = 53'h0_0001_0000_0000;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ZONE_DMA32 = 2'd0;
   localparam logic [1:0] ZONE_USER  = 2'd1;
   localparam logic [1:0] ZONE_HIGH  = 2'd2;

   localparam logic CSR_ENABLE   = 1'b0;
   localparam logic CSR_HIGH_END = 1'b1;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_REJECTED = 3'd2,
      ST_CACHED   = 3'd3,
      ST_DROPPED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COUNT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LCNT_W-1:0]  list_count;
      logic [TOTAL_W-1:0] zone_cached_pages;
      logic [1:0]         zone_used;
      logic [ORDER_W-1:0] block_order;
      logic [END_W-1:0]   range_end;
      logic [START_W-1:0] range_start;
      logic [ADDR_W-1:0]  result_address;
      status_type         status;
   } result_type;

   // smallest order whose power of two covers the page count
   function automatic logic [ORDER_W-1:0] round_order(input logic [PAGE_W-1:0] pages);
      logic [PAGE_W-1:0]  pm1;
      logic [ORDER_W-1:0] ord;
      pm1 = pages - PAGE_W'(1);
      ord = '0;
      if (pages > PAGE_W'(1)) begin
         for (int i = 0; i < PAGE_W; i++) begin
            if (pm1[i]) ord = ORDER_W'(i + 1);
         end
      end
      return ord;
   endfunction

endpackage

### design/zofbc_ram.sv
// ----------------------------------------------------------------------------
// zofbc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module zofbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/zoned_order_free_block_cache.sv
// ----------------------------------------------------------------------------
// zoned_order_free_block_cache
// Per zone and order LIFO cache of freed physical blocks.
// ----------------------------------------------------------------------------
// order: a free, miss or reject response is loaded into the output register
//    after the count RAM read, a hit after the count RAM read and then the
//    stack RAM read
// requests: one in work at a time; the next is taken once the response is loaded
// reset: synchronous, clears stack count valid bits, zone totals, the state
//    machine and the response valid bit; enable returns to 1 and the high zone end
//    to 4 GB; the stack RAM is not cleared and needs no clearing pass
module zoned_order_free_block_cache
   import zofbc_pkg::*;
#(
   parameter int MAX_ORDER    = 10,
   parameter int STACK_DEPTH  = 64,
   parameter int ADDRESS_BITS = 52
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,   // operation
   input  logic [71:0]   req_tdata,   // page_count, zone_tag, block_address
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [2:0]    rsp_tuser,   // status
   // result_address, range_start, range_end, block_order, zone_used,
   // zone_cached_pages, list_count
   output logic [175:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [0:0]    csr_index,
   input  logic [52:0]   csr_wdata
);

   localparam int ORDERS    = MAX_ORDER + 1;
   localparam int SLOTS     = ZONES * ORDERS;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int STK_DEPTH = SLOTS * STACK_DEPTH;
   localparam int STK_AW    = $clog2(STK_DEPTH);
   localparam int MEM_W     = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;

   // configuration
   logic             enable_ff, enable_in;
   logic [END_W-1:0] hze_ff, hze_in;

   // captured request
   logic               op_ff;
   logic [PAGE_W-1:0]  pages_ff;
   logic [MEM_W-1:0]   addr_ff;
   logic [1:0]         zone_ff;
   logic               zone_ok_ff;
   logic [ORDER_W-1:0] ord_ff;
   logic               ord_ok_ff;
   logic [SLOT_W-1:0]  slot_ff;

   state_type state_ff, state_in;

   logic [SLOTS-1:0]   cnt_valid_ff, cnt_valid_in;
   logic [TOTAL_W-1:0] tot_ff [ZONES];
   logic [TOTAL_W-1:0] tot_in [ZONES];

   result_type pend_ff, pend_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // request decode
   logic               req_fire;
   logic               in_op;
   logic [PAGE_W-1:0]  in_pages;
   logic [1:0]         in_tag;
   logic [MEM_W-1:0]   in_addr;
   logic [ADDR_W-1:0]  in_addr_m;
   logic [1:0]         in_zone;
   logic               in_zone_ok;
   logic [ORDER_W-1:0] in_ord;
   logic               in_ord_ok;
   logic [SLOT_W-1:0]  in_slot;

   // ram ports
   logic               cnt_rd_en, cnt_wr_en;
   logic [CNT_W-1:0]   cnt_rd, cnt_wdata;
   logic               stk_rd_en, stk_wr_en;
   logic [STK_AW-1:0]  stk_addr;
   logic [MEM_W-1:0]   stk_rd;

   // step datapath
   logic               out_free;
   logic [CNT_W-1:0]   cnt_cur, cnt_new, cnt_sel;
   logic               is_hit, is_push, is_ok;
   logic [TOTAL_W-1:0] pow, tot_new;
   logic [END_W-1:0]   hze_eff;
   result_type         res_now;
   logic               load_now, load_pend;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign in_op     = req_tuser;
   assign in_pages  = req_tdata[15:0];
   assign in_tag    = req_tdata[17:16];
   assign in_addr   = req_tdata[18 +: MEM_W];
   assign in_addr_m = ADDR_W'(in_addr);
   assign in_ord    = round_order(in_pages);
   assign in_ord_ok = in_ord <= ORDER_W'(MAX_ORDER);

   always_comb begin
      if (in_op == OP_ALLOC) begin
         in_zone_ok = in_tag < 2'(ZONES);
         in_zone    = in_zone_ok ? in_tag : ZONE_DMA32;
      end else begin
         in_zone_ok = 1'b1;
         if (END_W'(in_addr_m) < DMA32_LIMIT) begin
            in_zone = ZONE_DMA32;
         end else if (END_W'(in_addr_m) < USER_LIMIT) begin
            in_zone = ZONE_USER;
         end else begin
            in_zone = ZONE_HIGH;
         end
      end
      if (in_zone_ok && in_ord_ok) begin
         in_slot = SLOT_W'(in_zone) * SLOT_W'(ORDERS) + SLOT_W'(in_ord);
      end else begin
         in_slot = '0;
      end
   end

   // count and stack RAMs
   zofbc_ram #(
      .WIDTH(CNT_W),
      .DEPTH(SLOTS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (slot_ff),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_rd_en),
      .rd_addr (in_slot),
      .rd_data (cnt_rd)
   );

   zofbc_ram #(
      .WIDTH(MEM_W),
      .DEPTH(STK_DEPTH)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_addr),
      .wr_data (addr_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_addr),
      .rd_data (stk_rd)
   );

   // read-modify-write step on the count read back
   always_comb begin
      cnt_cur = cnt_valid_ff[slot_ff] ? cnt_rd : '0;
      is_ok   = zone_ok_ff && ord_ok_ff;
      is_hit  = 1'b0;
      is_push = 1'b0;
      pow     = TOTAL_W'(1) << ord_ff;
      hze_eff = (hze_ff > USER_LIMIT) ? hze_ff : USER_LIMIT;
      res_now = '0;
      res_now.block_order = ord_ff;
      res_now.zone_used   = zone_ff;
      if (op_ff == OP_ALLOC) begin
         if (!enable_ff || pages_ff == '0 || !is_ok) begin
            res_now.status = ST_REJECTED;
         end else if (cnt_cur != '0) begin
            is_hit         = 1'b1;
            res_now.status = ST_HIT;
         end else begin
            res_now.status = ST_MISS;
            unique case (zone_ff)
               ZONE_DMA32: begin
                  res_now.range_start = '0;
                  res_now.range_end   = DMA32_LIMIT;
               end
               ZONE_USER: begin
                  res_now.range_start = START_W'(DMA32_LIMIT);
                  res_now.range_end   = USER_LIMIT;
               end
               default: begin
                  res_now.range_start = START_W'(USER_LIMIT);
                  res_now.range_end   = hze_eff;
               end
            endcase
         end
      end else begin
         if (!enable_ff || pages_ff == '0 || addr_ff == '0 || !ord_ok_ff ||
             cnt_cur >= CNT_W'(STACK_DEPTH)) begin
            res_now.status = ST_DROPPED;
         end else begin
            is_push        = 1'b1;
            res_now.status = ST_CACHED;
         end
      end
      if (is_hit) begin
         cnt_new = cnt_cur - CNT_W'(1);
         tot_new = tot_ff[zone_ff] - pow;
      end else if (is_push) begin
         cnt_new = cnt_cur + CNT_W'(1);
         tot_new = tot_ff[zone_ff] + pow;
      end else begin
         cnt_new = cnt_cur;
         tot_new = tot_ff[zone_ff];
      end
      cnt_sel = is_hit ? cnt_new : cnt_cur;
      if (is_ok) begin
         res_now.zone_cached_pages = tot_new;
         res_now.list_count        = LCNT_W'(cnt_new);
      end
   end

   assign stk_addr  = STK_AW'(slot_ff) * STK_AW'(STACK_DEPTH) + STK_AW'(cnt_sel);
   assign cnt_wdata = cnt_new;

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_COUNT;
         end
         S_COUNT: begin
            if (!is_hit && out_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_tready = 1'b0;
      cnt_rd_en  = 1'b0;
      cnt_wr_en  = 1'b0;
      stk_rd_en  = 1'b0;
      stk_wr_en  = 1'b0;
      load_now   = 1'b0;
      load_pend  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cnt_rd_en  = req_fire;
         end
         S_COUNT: begin
            cnt_wr_en = is_hit || is_push;
            stk_wr_en = is_push;
            stk_rd_en = is_hit;
            load_now  = !is_hit && out_free;
         end
         S_DONE: begin
            load_pend = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      enable_in = enable_ff;
      hze_in    = hze_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE:   enable_in = csr_wdata[0];
            CSR_HIGH_END: hze_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cnt_valid_in = cnt_valid_ff;
      tot_in       = tot_ff;
      if (cnt_wr_en) begin
         cnt_valid_in[slot_ff] = 1'b1;
         tot_in[zone_ff]       = tot_new;
      end
   end

   always_comb begin
      pend_in = (state_ff == S_COUNT) ? res_now : pend_ff;
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_now) begin
         rsp_in       = res_now;
         rsp_valid_in = 1'b1;
      end else if (load_pend) begin
         rsp_in = pend_ff;
         if (pend_ff.status == ST_HIT) rsp_in.result_address = ADDR_W'(stk_rd);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b1;
         hze_ff       <= USER_LIMIT;
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < ZONES; z++) tot_ff[z] <= '0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         hze_ff       <= hze_in;
         cnt_valid_ff <= cnt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tot_ff       <= tot_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (req_fire) begin
         op_ff      <= in_op;
         pages_ff   <= in_pages;
         addr_ff    <= in_addr;
         zone_ff    <= in_zone;
         zone_ok_ff <= in_zone_ok;
         ord_ff     <= in_ord;
         ord_ok_ff  <= in_ord_ok;
         slot_ff    <= in_slot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {4'b0, rsp_ff.list_count, rsp_ff.zone_cached_pages,
                        rsp_ff.zone_used, rsp_ff.block_order, rsp_ff.range_end,
                        rsp_ff.range_start, rsp_ff.result_address};

endmodule

### design/zofbc_checker.sv
// ----------------------------------------------------------------------------
// zofbc_checker
// Port level checks of the zoned order free block cache, bound to the top.
// ----------------------------------------------------------------------------
module zofbc_checker
   import zofbc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [2:0]    rsp_tuser,
   input logic [175:0]  rsp_tdata
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one request in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // a miss carries a zone range and no address
   a_miss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_MISS |-> rsp_tdata[51:0] == '0 && rsp_tdata[137:85] != '0)
      else $error("miss without range");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind zoned_order_free_block_cache zofbc_checker u_zofbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb_zoned_order_free_block_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zoned_order_free_block_cache
// Self-checking bench for the zoned order free block cache. A driver feeds
// allocate and free requests from a queue, an in-bench model of the zone and
// order stacks predicts every response, and a monitor compares each field.
// Both stream sides stall at random, the response side once for a long stretch.
// ----------------------------------------------------------------------------
module tb_zoned_order_free_block_cache;
   import zofbc_pkg::*;

   localparam int MAX_ORDER    = 10;
   localparam int STACK_DEPTH  = 64;
   localparam int ADDRESS_BITS = 52;
   localparam int ORDERS       = MAX_ORDER + 1;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int STALL_CYCLES = 300;

   localparam logic [1:0] ZONE_INVALID = 2'd3;

   typedef struct {
      logic              op;
      logic [PAGE_W-1:0] pages;
      logic [1:0]        tag;
      logic [ADDR_W-1:0] addr;
   } block_request_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic           req_tuser = 1'b0;
   logic [71:0]    req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [2:0]     rsp_tuser;
   logic [175:0]   rsp_tdata;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [0:0]     csr_index = '0;
   logic [52:0]    csr_wdata = '0;

   // predicted cache contents
   logic              cache_enable = 1'b1;
   logic [END_W-1:0]  high_zone_limit = USER_LIMIT;
   logic [ADDR_W-1:0] cached_blocks [ZONES][ORDERS][STACK_DEPTH];
   int unsigned       stack_fill [ZONES][ORDERS] = '{default: 0};
   logic [TOTAL_W-1:0] zone_pages [ZONES] = '{default: '0};

   block_request_type pending_requests[$];
   result_type        expected_results[$];
   block_request_type offered_request;

   int  idle_pct = 0;
   bit  calm_tail = 1'b0;
   bit  hold_rsp_now = 1'b0;
   bit  rsp_held_once = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   int  error_count = 0;
   int  requests_accepted = 0;
   int  outcome_count [8] = '{default: 0};

   zoned_order_free_block_cache #(
      .MAX_ORDER    (MAX_ORDER),
      .STACK_DEPTH  (STACK_DEPTH),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // one cache step: pop on allocate, push on free, counts after the step
   function automatic result_type predict_cache_step(block_request_type r);
      result_type  res;
      int unsigned ord;
      logic [1:0]  zone;
      bit          zone_ok;
      bit          ord_ok;
      res = '0;
      ord = 0;
      while ((32'd1 << ord) < r.pages) ord++;
      ord_ok = (ord <= MAX_ORDER);
      res.block_order = ORDER_W'(ord);
      if (r.op == OP_ALLOC) begin
         zone_ok = (r.tag < ZONES);
         zone = zone_ok ? r.tag : ZONE_DMA32;
         if (!cache_enable || r.pages == 0 || !zone_ok || !ord_ok) begin
            res.status = ST_REJECTED;
         end else if (stack_fill[zone][ord] > 0) begin
            stack_fill[zone][ord]--;
            res.result_address = cached_blocks[zone][ord][stack_fill[zone][ord]];
            zone_pages[zone] = zone_pages[zone] - TOTAL_W'(1 << ord);
            res.status = ST_HIT;
         end else begin
            res.status = ST_MISS;
            case (zone)
               ZONE_DMA32: begin
                  res.range_start = '0;
                  res.range_end   = DMA32_LIMIT;
               end
               ZONE_USER: begin
                  res.range_start = START_W'(DMA32_LIMIT);
                  res.range_end   = USER_LIMIT;
               end
               default: begin
                  // a high end below 4 GB counts as 4 GB
                  res.range_start = START_W'(USER_LIMIT);
                  res.range_end   = (high_zone_limit > USER_LIMIT) ? high_zone_limit
                                                                   : USER_LIMIT;
               end
            endcase
         end
      end else begin
         zone = (r.addr < DMA32_LIMIT) ? ZONE_DMA32 :
                (r.addr < USER_LIMIT)  ? ZONE_USER  : ZONE_HIGH;
         zone_ok = 1'b1;
         if (!cache_enable || r.pages == 0 || r.addr == 0 || !ord_ok ||
             stack_fill[zone][ord] >= STACK_DEPTH) begin
            res.status = ST_DROPPED;
         end else begin
            cached_blocks[zone][ord][stack_fill[zone][ord]] = r.addr;
            stack_fill[zone][ord]++;
            zone_pages[zone] = zone_pages[zone] + TOTAL_W'(1 << ord);
            res.status = ST_CACHED;
         end
      end
      res.zone_used = zone;
      if (zone_ok && ord_ok) begin
         res.zone_cached_pages = zone_pages[zone];
         res.list_count        = LCNT_W'(stack_fill[zone][ord]);
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] zone_address(int z);
      logic [ADDR_W-1:0] a;
      case (z)
         0:       a = ADDR_W'($urandom_range(1, 32'h3FFF_FFFF));
         1:       a = ADDR_W'($urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
         default: begin
            a = random_address();
            if (a < USER_LIMIT) a = a | ADDR_W'(USER_LIMIT);
         end
      endcase
      return a;
   endfunction

   function automatic logic [PAGE_W-1:0] pages_for_order(int o);
      if (o == 0) return PAGE_W'(1);
      return PAGE_W'($urandom_range((1 << (o - 1)) + 1, 1 << o));
   endfunction

   task automatic enqueue_request(input logic op, input logic [PAGE_W-1:0] pages,
                                  input logic [1:0] tag, input logic [ADDR_W-1:0] addr);
      block_request_type r;
      r.op    = op;
      r.pages = pages;
      r.tag   = tag;
      r.addr  = addr;
      pending_requests.push_back(r);
   endtask

   // mostly push runs followed by pop runs on one stack, the rest raw noise
   task automatic queue_random_traffic(input int count);
      int queued;
      int z;
      int o;
      int frees;
      int allocs;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            z      = $urandom_range(0, 2);
            o      = $urandom_range(0, MAX_ORDER);
            frees  = $urandom_range(1, 8);
            allocs = $urandom_range(1, frees + 2);
            repeat (frees)
               enqueue_request(OP_FREE, pages_for_order(o), 2'($urandom), zone_address(z));
            repeat (allocs)
               enqueue_request(OP_ALLOC, pages_for_order(o), 2'(z), random_address());
            queued += frees + allocs;
         end else begin
            enqueue_request(1'($urandom), PAGE_W'($urandom), 2'($urandom), random_address());
            queued++;
         end
      end
   endtask

   // overfill one stack, then drain it past empty
   task automatic queue_stack_flood();
      int z;
      int o;
      z = $urandom_range(0, 2);
      o = $urandom_range(0, MAX_ORDER);
      repeat (STACK_DEPTH + 2)
         enqueue_request(OP_FREE, pages_for_order(o), 2'($urandom), zone_address(z));
      repeat (STACK_DEPTH + 3)
         enqueue_request(OP_ALLOC, pages_for_order(o), 2'(z), random_address());
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [52:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ENABLE) cache_enable = value[0];
      else high_zone_limit = value;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_cache_step(offered_request));
            requests_accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               offered_request = pending_requests.pop_front();
               req_tuser  <= offered_request.op;
               req_tdata  <= {2'b00, offered_request.addr, offered_request.tag,
                              offered_request.pages};
               req_tvalid <= 1'b1;
               if (!calm_tail && $urandom_range(0, 99) < idle_pct)
                  req_gap = $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generator
   always @(posedge clock) begin
      result_type got;
      result_type want;
      logic       ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'({rsp_tdata[171:0], rsp_tuser});
            outcome_count[rsp_tuser]++;
            if (expected_results.size() == 0) begin
               $display("%0t: response with nothing expected, actual %0h", $time,
                        {rsp_tdata[171:0], rsp_tuser});
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 64'(got.status), 64'(want.status));
               check_field("result_address", 64'(got.result_address),
                           64'(want.result_address));
               check_field("range_start", 64'(got.range_start), 64'(want.range_start));
               check_field("range_end", 64'(got.range_end), 64'(want.range_end));
               check_field("block_order", 64'(got.block_order), 64'(want.block_order));
               check_field("zone_used", 64'(got.zone_used), 64'(want.zone_used));
               check_field("zone_cached_pages", 64'(got.zone_cached_pages),
                           64'(want.zone_cached_pages));
               check_field("list_count", 64'(got.list_count), 64'(want.list_count));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (hold_rsp_now && !rsp_held_once) begin
            rsp_held_once = 1'b1;
            hold_left = STALL_CYCLES;
            ready_next = 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
            if (!calm_tail && $urandom_range(0, 99) < idle_pct)
               rsp_gap = $urandom_range(1, 11);
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 25;

      // misses per zone, rejects and drops
      enqueue_request(OP_ALLOC, 16'd1, ZONE_DMA32, random_address());
      enqueue_request(OP_ALLOC, 16'd2, ZONE_USER, random_address());
      enqueue_request(OP_ALLOC, 16'd1024, ZONE_HIGH, random_address());
      enqueue_request(OP_ALLOC, 16'd1, ZONE_INVALID, random_address());
      enqueue_request(OP_ALLOC, 16'd0, ZONE_DMA32, random_address());
      enqueue_request(OP_ALLOC, 16'd1025, ZONE_USER, random_address());
      enqueue_request(OP_ALLOC, 16'hFFFF, ZONE_INVALID, random_address());
      enqueue_request(OP_FREE, 16'd1, 2'($urandom), '0);
      enqueue_request(OP_FREE, 16'd0, 2'($urandom), 52'h1000);
      enqueue_request(OP_FREE, 16'd2048, 2'($urandom), 52'h2000);
      // zone edges, then pops in last-in-first-out order
      enqueue_request(OP_FREE, 16'd1, 2'($urandom), 52'h1);
      enqueue_request(OP_FREE, 16'd1, 2'($urandom), 52'h3FFF_FFFF);
      enqueue_request(OP_FREE, 16'd3, 2'($urandom), 52'h4000_0000);
      enqueue_request(OP_FREE, 16'd1024, 2'($urandom), 52'hFFFF_FFFF);
      enqueue_request(OP_FREE, 16'd5, 2'($urandom), 52'h1_0000_0000);
      enqueue_request(OP_FREE, 16'hFFFF, 2'($urandom), 52'hF_FFFF_FFFF_FFFF);
      enqueue_request(OP_FREE, 16'd1, 2'($urandom), 52'hF_FFFF_FFFF_FFFF);
      enqueue_request(OP_ALLOC, 16'd1, ZONE_DMA32, random_address());
      enqueue_request(OP_ALLOC, 16'd1, ZONE_DMA32, random_address());
      enqueue_request(OP_ALLOC, 16'd1, ZONE_DMA32, random_address());
      enqueue_request(OP_ALLOC, 16'd4, ZONE_USER, random_address());
      enqueue_request(OP_ALLOC, 16'd513, ZONE_USER, random_address());
      enqueue_request(OP_ALLOC, 16'd8, ZONE_HIGH, random_address());
      enqueue_request(OP_ALLOC, 16'd1, ZONE_HIGH, random_address());
      wait_drained();

      // high zone end at its top, below 4 GB and all ones; high stacks are empty
      write_csr(CSR_HIGH_END, 53'h10_0000_0000_0000);
      enqueue_request(OP_ALLOC, 16'd1, ZONE_HIGH, random_address());
      wait_drained();
      write_csr(CSR_HIGH_END, 53'd4096);
      enqueue_request(OP_ALLOC, 16'd64, ZONE_HIGH, random_address());
      wait_drained();
      write_csr(CSR_HIGH_END, '1);
      enqueue_request(OP_ALLOC, 16'd2, ZONE_HIGH, random_address());
      wait_drained();

      // disabled: nothing may change
      write_csr(CSR_ENABLE, {random_address(), 1'b0});
      queue_random_traffic(12);
      wait_drained();
      write_csr(CSR_ENABLE, 53'd1);

      queue_random_traffic(200);
      wait_drained();
      idle_pct = 0;
      queue_random_traffic(150);
      wait_drained();

      // long response stall while a full stack is pushed and drained
      idle_pct = 10;
      hold_rsp_now = 1'b1;
      queue_stack_flood();
      wait_drained();
      idle_pct = 40;
      queue_random_traffic(100);
      wait_drained();

      begin
         logic [END_W-1:0] hze;
         hze = END_W'(random_address());
         if (hze < USER_LIMIT) hze = hze | USER_LIMIT;
         write_csr(CSR_HIGH_END, hze);
      end
      calm_tail = 1'b1;
      queue_random_traffic(100);
      wait_drained();

      $display("%0d requests: %0d hits, %0d misses, %0d rejects, %0d cached, %0d dropped",
               requests_accepted, outcome_count[ST_HIT], outcome_count[ST_MISS],
               outcome_count[ST_REJECTED], outcome_count[ST_CACHED],
               outcome_count[ST_DROPPED]);
      $display("covered disable, high zone end extremes, a full stack and a long stall");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
